[src/tcsa_pkg.sv]
package tcsa_pkg;

    localparam int DIM_W     = 13;
    localparam int MAX_DIM   = 4096;
    localparam int FRAC_W    = 16;
    localparam int SCALE_W   = 24;
    localparam int COORD_W   = 12;
    localparam int PROD_W    = SCALE_W + DIM_W;
    localparam int AREA_W    = 2 * DIM_W;
    localparam int CROP_NUM_W = AREA_W + 2 * FRAC_W;
    localparam int CROP_Q_W  = DIM_W + FRAC_W + 1;
    localparam int FRAC_NUM_W = COORD_W + FRAC_W;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [DIM_W-1:0] SOURCE_WIDTH_RST  = DIM_W'(64);
    localparam logic [DIM_W-1:0] SOURCE_HEIGHT_RST = DIM_W'(64);
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = DIM_W'(1024);

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_SCREEN_HEIGHT = 2'd2
    } reg_index_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W:0] lim;
        lim = (DIM_W+1)'(MAX_DIM);
        if ({1'b0, v} > lim)
            return lim[DIM_W-1:0];
        return v;
    endfunction

endpackage

[src/tcsa_div.sv]
module tcsa_div #(
    parameter int NUM_W = 58,
    parameter int DEN_W = 37,
    parameter int Q_W   = 30
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    localparam int REM_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [REM_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [Q_W-1:0]   quo_next;

        if (i == 0) begin : g_first
            assign rem_in = REM_W'(num);
            assign den_in = den;
            assign quo_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        always_comb
        begin
            trial    = REM_W'(den_in) << (Q_W - 1 - i);
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                quo_next[Q_W-1-i] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= rem_next;
            den_reg[i] <= den_in;
            quo_reg[i] <= quo_next;
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

[src/texture_column_scale_address.sv]
// Scaled texture column address generator. One destination pixel request is
// taken in every cycle (busy stays low). Its result appears with done high
// for one cycle, once the request has passed stages a, b, c, the two 30-stage
// pipelined dividers, stage m and the output registers. The receiver cannot
// stall, so done is never held off. The user must write registers through
// the APB port only while no request is in flight; the block itself does
// not enforce this. Writes above the texture or screen limit saturate.
module texture_column_scale_address (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcsa_pkg::ADDR_W-1:0]        paddr,
    input  logic [tcsa_pkg::DATA_W-1:0]        pwdata,
    output logic [tcsa_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic [tcsa_pkg::SCALE_W-1:0]       scale_factor,
    input  logic signed [tcsa_pkg::DIM_W-1:0]  texture_column,
    input  logic [tcsa_pkg::COORD_W-1:0]       screen_column,
    input  logic [tcsa_pkg::COORD_W-1:0]       screen_row,
    output logic                               done,
    output logic                               draw,
    output logic [tcsa_pkg::COORD_W-1:0]       fetch_column,
    output logic [tcsa_pkg::COORD_W-1:0]       fetch_row,
    output logic [tcsa_pkg::COORD_W-1:0]       store_column,
    output logic [tcsa_pkg::COORD_W-1:0]       store_row
);

    localparam int DW  = tcsa_pkg::DIM_W;
    localparam int CW  = tcsa_pkg::COORD_W;
    localparam int FW  = tcsa_pkg::FRAC_W;
    localparam int PW  = tcsa_pkg::PROD_W;
    localparam int QW  = tcsa_pkg::CROP_Q_W;
    localparam int PFW = FW + QW;
    localparam int PCW = FW + DW;
    localparam int CSW = QW - 1;
    localparam int SUMW = PFW - FW + 1;
    localparam int ROWW = SUMW - FW;

    typedef struct packed {
        logic          full;
        logic          in_range;
        logic          col_ok;
        logic [CW-1:0] tcol;
        logic [CW-1:0] scol;
        logic [CW-1:0] srow;
    } side_t;

    logic [DW-1:0] source_width_reg;
    logic [DW-1:0] source_height_reg;
    logic [DW-1:0] screen_height_reg;
    logic          cfg_we;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= tcsa_pkg::SOURCE_WIDTH_RST;
            source_height_reg <= tcsa_pkg::SOURCE_HEIGHT_RST;
            screen_height_reg <= tcsa_pkg::SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                tcsa_pkg::REG_SOURCE_WIDTH:
                    source_width_reg  <= tcsa_pkg::clamp_dim(pwdata[DW-1:0]);
                tcsa_pkg::REG_SOURCE_HEIGHT:
                    source_height_reg <= tcsa_pkg::clamp_dim(pwdata[DW-1:0]);
                tcsa_pkg::REG_SCREEN_HEIGHT:
                    screen_height_reg <= tcsa_pkg::clamp_dim(pwdata[DW-1:0]);
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tcsa_pkg::REG_SOURCE_WIDTH:  prdata = 32'(source_width_reg);
            tcsa_pkg::REG_SOURCE_HEIGHT: prdata = 32'(source_height_reg);
            tcsa_pkg::REG_SCREEN_HEIGHT: prdata = 32'(screen_height_reg);
            default:                     prdata = '0;
        endcase
    end

    // stage a: capture request
    logic                              va_reg;
    logic [tcsa_pkg::SCALE_W-1:0]      scale_a_reg;
    logic [DW-1:0]                     tcol_a_reg;
    logic [CW-1:0]                     scol_a_reg;
    logic [CW-1:0]                     srow_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        scale_a_reg <= scale_factor;
        tcol_a_reg  <= texture_column;
        scol_a_reg  <= screen_column;
        srow_a_reg  <= screen_row;
    end

    // stage b: products
    logic                              vb_reg;
    logic [PW-1:0]                     r_b_reg;
    logic [tcsa_pkg::AREA_W-1:0]       area_b_reg;
    logic                              nz_b_reg;
    logic                              col_ok_b_reg;
    logic [CW-1:0]                     tcol_b_reg;
    logic [CW-1:0]                     scol_b_reg;
    logic [CW-1:0]                     srow_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        r_b_reg      <= PW'(scale_a_reg) * PW'(source_height_reg);
        area_b_reg   <= tcsa_pkg::AREA_W'(source_height_reg)
                        * tcsa_pkg::AREA_W'(screen_height_reg);
        nz_b_reg     <= (scale_a_reg != '0) && (screen_height_reg != '0)
                        && (source_height_reg != '0);
        col_ok_b_reg <= !tcol_a_reg[DW-1] && (tcol_a_reg < source_width_reg);
        tcol_b_reg   <= tcol_a_reg[CW-1:0];
        scol_b_reg   <= scol_a_reg;
        srow_b_reg   <= srow_a_reg;
    end

    // stage c: case select, range test, divider operands
    logic          full_c;
    logic [DW-1:0] len_c;
    logic [CW-1:0] start_c;
    logic [DW:0]   end_c;
    logic          in_c;
    logic [CW-1:0] diff_c;
    logic [DW-1:0] sub_c;

    always_comb
    begin
        full_c  = r_b_reg >= PW'({screen_height_reg, FW'(0)});
        len_c   = r_b_reg[FW+DW-1:FW];
        sub_c   = screen_height_reg - len_c;
        start_c = sub_c[DW-1:1];
        end_c   = (DW+1)'(start_c) + (DW+1)'(len_c);
        diff_c  = srow_b_reg - start_c;
        if (full_c)
            in_c = ({1'b0, srow_b_reg} < screen_height_reg);
        else
            in_c = (len_c != '0) && (srow_b_reg >= start_c)
                   && ((DW+1)'(srow_b_reg) < end_c);
    end

    logic                               vc_reg;
    side_t                              side_c_reg;
    logic [tcsa_pkg::CROP_NUM_W-1:0]    num1_c_reg;
    logic [PW-1:0]                      den1_c_reg;
    logic [tcsa_pkg::FRAC_NUM_W-1:0]    num2_c_reg;
    logic [DW-1:0]                      den2_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        side_c_reg.full     <= full_c;
        side_c_reg.in_range <= nz_b_reg && in_c;
        side_c_reg.col_ok   <= col_ok_b_reg;
        side_c_reg.tcol     <= tcol_b_reg;
        side_c_reg.scol     <= scol_b_reg;
        side_c_reg.srow     <= srow_b_reg;
        num1_c_reg          <= {area_b_reg, (2*FW)'(0)};
        den1_c_reg          <= r_b_reg;
        num2_c_reg          <= full_c ? {srow_b_reg, FW'(0)} : {diff_c, FW'(0)};
        den2_c_reg          <= full_c ? screen_height_reg : len_c;
    end

    logic [QW-1:0] crop_q;
    logic [QW-1:0] frac_q;

    tcsa_div #(
        .NUM_W (tcsa_pkg::CROP_NUM_W),
        .DEN_W (PW),
        .Q_W   (QW)
    ) u_crop_div (
        .clk (clk),
        .num (num1_c_reg),
        .den (den1_c_reg),
        .quo (crop_q)
    );

    tcsa_div #(
        .NUM_W (tcsa_pkg::FRAC_NUM_W),
        .DEN_W (DW),
        .Q_W   (QW)
    ) u_frac_div (
        .clk (clk),
        .num (num2_c_reg),
        .den (den2_c_reg),
        .quo (frac_q)
    );

    // align sideband with divider latency
    logic  vd_reg   [QW];
    side_t side_d_reg [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
                vd_reg[i] <= 1'b0;
        end
        else
        begin
            vd_reg[0] <= vc_reg;
            for (int i = 1; i < QW; i++)
                vd_reg[i] <= vd_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_d_reg[0] <= side_c_reg;
        for (int i = 1; i < QW; i++)
            side_d_reg[i] <= side_d_reg[i-1];
    end

    // stage m: row products
    logic           vm_reg;
    side_t          side_m_reg;
    logic [PFW-1:0] prod_f_m_reg;
    logic [PCW-1:0] prod_c_m_reg;
    logic [CSW-1:0] cstart_m_reg;
    logic [QW-1:0]  cdiff_m;

    assign cdiff_m = QW'({source_height_reg, FW'(0)}) - crop_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else
            vm_reg <= vd_reg[QW-1];
    end

    always_ff @(posedge clk)
    begin
        side_m_reg   <= side_d_reg[QW-1];
        prod_f_m_reg <= PFW'(frac_q[FW-1:0]) * PFW'(crop_q);
        prod_c_m_reg <= PCW'(frac_q[FW-1:0]) * PCW'(source_height_reg);
        cstart_m_reg <= cdiff_m[QW-1:1];
    end

    // stage f: row select and draw decision
    logic [SUMW-1:0] sum_f;
    logic [ROWW-1:0] row_f;
    logic            draw_f;

    always_comb
    begin
        sum_f = SUMW'(prod_f_m_reg[PFW-1:FW]) + SUMW'(cstart_m_reg);
        if (side_m_reg.full)
            row_f = sum_f[SUMW-1:FW];
        else
            row_f = ROWW'(prod_c_m_reg[PCW-1:FW]);
        draw_f = side_m_reg.in_range && side_m_reg.col_ok
                 && (row_f < ROWW'(source_height_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= vm_reg;
    end

    always_ff @(posedge clk)
    begin
        draw         <= draw_f;
        fetch_column <= draw_f ? side_m_reg.tcol : '0;
        fetch_row    <= draw_f ? row_f[CW-1:0] : '0;
        store_column <= side_m_reg.scol;
        store_row    <= side_m_reg.srow;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic                         draw;
        logic [tcsa_pkg::COORD_W-1:0] fetch_column;
        logic [tcsa_pkg::COORD_W-1:0] fetch_row;
        logic [tcsa_pkg::COORD_W-1:0] store_column;
        logic [tcsa_pkg::COORD_W-1:0] store_row;
    } pixel_t;

    typedef struct {
        logic [tcsa_pkg::SCALE_W-1:0] scale;
        logic [tcsa_pkg::DIM_W-1:0]   tcol;
        logic [tcsa_pkg::COORD_W-1:0] scol;
        logic [tcsa_pkg::COORD_W-1:0] srow;
        bit                           typed;
        logic                         draw;
        logic [tcsa_pkg::COORD_W-1:0] fcol;
        logic [tcsa_pkg::COORD_W-1:0] frow;
    } vector_t;

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [tcsa_pkg::ADDR_W-1:0]         paddr;
    logic [tcsa_pkg::DATA_W-1:0]         pwdata;
    logic [tcsa_pkg::DATA_W-1:0]         prdata;
    logic                                pready;
    logic                                start;
    logic                                busy;
    logic [tcsa_pkg::SCALE_W-1:0]        scale_factor;
    logic signed [tcsa_pkg::DIM_W-1:0]   texture_column;
    logic [tcsa_pkg::COORD_W-1:0]        screen_column;
    logic [tcsa_pkg::COORD_W-1:0]        screen_row;
    logic                                done;
    logic                                draw;
    logic [tcsa_pkg::COORD_W-1:0]        fetch_column;
    logic [tcsa_pkg::COORD_W-1:0]        fetch_row;
    logic [tcsa_pkg::COORD_W-1:0]        store_column;
    logic [tcsa_pkg::COORD_W-1:0]        store_row;

    logic [tcsa_pkg::DIM_W-1:0] cfg_width;
    logic [tcsa_pkg::DIM_W-1:0] cfg_height;
    logic [tcsa_pkg::DIM_W-1:0] cfg_screen;

    pixel_t     pixel_q[$];
    int         mismatches;
    int         quiet_cycles;
    int         idle_pct;
    bit         typed_now;
    pixel_t     typed_pixel;
    vector_t    vectors[$];

    texture_column_scale_address u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .scale_factor   (scale_factor),
        .texture_column (texture_column),
        .screen_column  (screen_column),
        .screen_row     (screen_row),
        .done           (done),
        .draw           (draw),
        .fetch_column   (fetch_column),
        .fetch_row      (fetch_row),
        .store_column   (store_column),
        .store_row      (store_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic pixel_t predict_pixel(input logic [tcsa_pkg::SCALE_W-1:0] sc,
                                             input logic [tcsa_pkg::DIM_W-1:0] tc,
                                             input logic [tcsa_pkg::COORD_W-1:0] scl,
                                             input logic [tcsa_pkg::COORD_W-1:0] srw);
        pixel_t p;
        logic [63:0] sh;
        logic [63:0] scr;
        logic [63:0] r;
        logic [63:0] crop;
        logic [63:0] cstart;
        logic [63:0] frac;
        logic [63:0] row;
        logic [63:0] len;
        logic [63:0] first;
        bit          col_ok;
        bit          in_range;
        sh = 64'(cfg_height);
        scr = 64'(cfg_screen);
        row = 0;
        in_range = 0;
        col_ok = !tc[tcsa_pkg::DIM_W-1] && (tc < cfg_width);
        if (sc != 0 && scr != 0 && sh != 0)
        begin
            r = 64'(sc) * sh;
            if (r >= (scr << 16))
            begin
                crop = ((sh * scr) << 32) / r;
                cstart = ((sh << 16) - crop) >> 1;
                if (64'(srw) < scr)
                begin
                    frac = (64'(srw) << 16) / scr;
                    row = (((frac * crop) >> 16) + cstart) >> 16;
                    in_range = 1;
                end
            end
            else
            begin
                len = r >> 16;
                if (len != 0)
                begin
                    first = (scr - len) >> 1;
                    if (64'(srw) >= first && 64'(srw) < first + len)
                    begin
                        frac = ((64'(srw) - first) << 16) / len;
                        row = (frac * sh) >> 16;
                        in_range = 1;
                    end
                end
            end
        end
        p.draw = in_range && col_ok && (row < sh);
        p.fetch_column = p.draw ? tc[tcsa_pkg::COORD_W-1:0] : '0;
        p.fetch_row = p.draw ? row[tcsa_pkg::COORD_W-1:0] : '0;
        p.store_column = scl;
        p.store_row = srw;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        logic [tcsa_pkg::DIM_W-1:0] v;
        if (rst_n && psel && penable && pwrite && pready)
        begin
            v = pwdata[tcsa_pkg::DIM_W-1:0];
            if (v > tcsa_pkg::DIM_W'(tcsa_pkg::MAX_DIM))
                v = tcsa_pkg::DIM_W'(tcsa_pkg::MAX_DIM);
            case (paddr)
                tcsa_pkg::ADDR_W'(4 * tcsa_pkg::REG_SOURCE_WIDTH):  cfg_width <= v;
                tcsa_pkg::ADDR_W'(4 * tcsa_pkg::REG_SOURCE_HEIGHT): cfg_height <= v;
                tcsa_pkg::ADDR_W'(4 * tcsa_pkg::REG_SCREEN_HEIGHT): cfg_screen <= v;
                default: ;
            endcase
        end
        if (rst_n && start && !busy)
        begin
            if (typed_now)
                pixel_q.push_back(typed_pixel);
            else
                pixel_q.push_back(predict_pixel(scale_factor, texture_column,
                                                screen_column, screen_row));
        end
        if (rst_n && done)
        begin
            if (pixel_q.size() == 0)
                report_mismatch("unexpected transfer", 32'(store_row), 0);
            else
            begin
                want = pixel_q.pop_front();
                if (draw !== want.draw)
                    report_mismatch("draw", 32'(draw), 32'(want.draw));
                if (fetch_column !== want.fetch_column)
                    report_mismatch("fetch_column", 32'(fetch_column),
                                    32'(want.fetch_column));
                if (fetch_row !== want.fetch_row)
                    report_mismatch("fetch_row", 32'(fetch_row), 32'(want.fetch_row));
                if (store_column !== want.store_column)
                    report_mismatch("store_column", 32'(store_column),
                                    32'(want.store_column));
                if (store_row !== want.store_row)
                    report_mismatch("store_row", 32'(store_row), 32'(want.store_row));
            end
        end
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic drain();
        start <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tcsa_pkg::ADDR_W-1:0] addr,
                             input logic [tcsa_pkg::DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [tcsa_pkg::DATA_W-1:0] w,
                             input logic [tcsa_pkg::DATA_W-1:0] h,
                             input logic [tcsa_pkg::DATA_W-1:0] s);
        drain();
        write_reg(tcsa_pkg::ADDR_W'(4 * tcsa_pkg::REG_SOURCE_WIDTH), w);
        write_reg(tcsa_pkg::ADDR_W'(4 * tcsa_pkg::REG_SOURCE_HEIGHT), h);
        write_reg(tcsa_pkg::ADDR_W'(4 * tcsa_pkg::REG_SCREEN_HEIGHT), s);
    endtask

    task automatic send_pixel(input vector_t vec);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        scale_factor <= vec.scale;
        texture_column <= vec.tcol;
        screen_column <= vec.scol;
        screen_row <= vec.srow;
        typed_now <= vec.typed;
        typed_pixel <= '{vec.draw, vec.fcol, vec.frow, vec.scol, vec.srow};
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic vector_t pick_vector();
        vector_t v;
        logic [63:0] target;
        v.typed = 0;
        v.draw = 0;
        v.fcol = 0;
        v.frow = 0;
        case ($urandom_range(0, 9))
            0: v.scale = tcsa_pkg::SCALE_W'($urandom);
            1: v.scale = tcsa_pkg::SCALE_W'($urandom_range(0, 3));
            default:
            begin
                target = (64'(cfg_screen) << 16)
                         / (cfg_height == 0 ? 64'd1 : 64'(cfg_height));
                target = target * $urandom_range(10, 300) / 100 + $urandom_range(0, 255);
                v.scale = target > 64'hFFFFFF ? tcsa_pkg::SCALE_W'(24'hFFFFFF)
                                              : tcsa_pkg::SCALE_W'(target);
            end
        endcase
        if ($urandom_range(0, 9) < 8 && cfg_width != 0)
            v.tcol = tcsa_pkg::DIM_W'($urandom_range(0, cfg_width - 1));
        else
            v.tcol = tcsa_pkg::DIM_W'($urandom);
        if ($urandom_range(0, 9) < 8)
            v.srow = tcsa_pkg::COORD_W'($urandom_range(0, cfg_screen));
        else
            v.srow = tcsa_pkg::COORD_W'($urandom);
        v.scol = tcsa_pkg::COORD_W'($urandom);
        return v;
    endfunction

    initial
    begin
        vector_t v;
        int      cfg;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        scale_factor = '0;
        texture_column = '0;
        screen_column = '0;
        screen_row = '0;
        typed_now = 0;
        typed_pixel = '0;
        mismatches = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        cfg_width = tcsa_pkg::SOURCE_WIDTH_RST;
        cfg_height = tcsa_pkg::SOURCE_HEIGHT_RST;
        cfg_screen = tcsa_pkg::SCREEN_HEIGHT_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        vectors = '{
            '{24'h0,      13'd0,    12'd0,    12'd0,    1, 1'b0, 12'd0,  12'd0},
            '{24'h10000,  13'd5,    12'd7,    12'd480,  1, 1'b1, 12'd5,  12'd0},
            '{24'h10000,  13'd5,    12'd7,    12'd479,  1, 1'b0, 12'd0,  12'd0},
            '{24'h10000,  13'd5,    12'd7,    12'd544,  1, 1'b0, 12'd0,  12'd0},
            '{24'h10000,  13'd5,    12'd7,    12'd543,  0, 1'b0, 12'd0,  12'd0},
            '{24'h10000,  13'h1FFF, 12'd1,    12'd500,  1, 1'b0, 12'd0,  12'd0},
            '{24'h10000,  13'h1000, 12'd1,    12'd500,  1, 1'b0, 12'd0,  12'd0},
            '{24'h10000,  13'd64,   12'd1,    12'd500,  1, 1'b0, 12'd0,  12'd0},
            '{24'h10000,  13'd63,   12'd1,    12'd500,  0, 1'b0, 12'd0,  12'd0},
            '{24'h1,      13'd3,    12'd2,    12'd512,  1, 1'b0, 12'd0,  12'd0},
            '{24'h0FFFF,  13'd3,    12'd2,    12'd512,  0, 1'b0, 12'd0,  12'd0},
            '{24'h100000, 13'd3,    12'd2,    12'd0,    0, 1'b0, 12'd0,  12'd0},
            '{24'h100000, 13'd3,    12'd2,    12'd1023, 0, 1'b0, 12'd0,  12'd0},
            '{24'h100000, 13'd3,    12'd2,    12'd1024, 1, 1'b0, 12'd0,  12'd0},
            '{24'hFFFFFF, 13'd0,    12'd4095, 12'd0,    0, 1'b0, 12'd0,  12'd0},
            '{24'hFFFFFF, 13'd63,   12'd4095, 12'd1023, 0, 1'b0, 12'd0,  12'd0},
            '{24'hFFFFFF, 13'd63,   12'd4095, 12'd4095, 1, 1'b0, 12'd0,  12'd0}
        };
        foreach (vectors[i])
            send_pixel(vectors[i]);

        // saturated source height exercises the wide fetch row
        configure(32'hFFFF_FFFF, 32'h0000_1FFF, 32'd4096);
        send_pixel('{24'h10000, 13'd4095, 12'd9, 12'd4095, 0, 1'b0, 12'd0, 12'd0});
        send_pixel('{24'h8000,  13'd100,  12'd9, 12'd3000, 0, 1'b0, 12'd0, 12'd0});
        configure(32'd0, 32'd64, 32'd1024);
        send_pixel('{24'h10000, 13'd0, 12'd9, 12'd500, 1, 1'b0, 12'd0, 12'd0});
        configure(32'd64, 32'd0, 32'd1024);
        send_pixel('{24'h10000, 13'd0, 12'd9, 12'd500, 1, 1'b0, 12'd0, 12'd0});
        configure(32'd64, 32'd64, 32'd0);
        send_pixel('{24'h10000, 13'd0, 12'd9, 12'd0, 1, 1'b0, 12'd0, 12'd0});
        drain();
        write_reg(tcsa_pkg::ADDR_W'(12), 32'd1);

        for (cfg = 0; cfg < 12; cfg++)
        begin
            case (cfg % 4)
                0: idle_pct = 0;
                1: idle_pct = 53;
                2: idle_pct = 0;
                default: idle_pct = 10;
            endcase
            case (cfg)
                0: configure(32'd1, 32'd1, 32'd1);
                1: configure(32'd4096, 32'd4096, 32'd4096);
                2: configure(32'd64, 32'd64, 32'd1024);
                default: configure($urandom_range(1, 300), $urandom_range(1, 300),
                                   $urandom_range(1, 4096));
            endcase
            repeat (150)
            begin
                send_pixel(pick_vector());
                if (cfg == 5 && $urandom_range(0, 49) == 0)
                    drain();
            end
        end

        drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
